/* hw/rtl/crc16cbc_pkg.sv */
// Shared types, constants and CRC functions for the callsign bit corrector.
`timescale 1ns / 1ps

package crc16cbc_pkg;

    localparam int WORD_W           = 64;
    localparam int STATUS_W         = 2;
    localparam int CB_DEFAULT_BYTES = 8;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_SINGLE = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_FAIL   = 2'd3
    } t_status;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic    load;
        logic    crc_step;
        logic    single_init;
        logic    single_step;
        logic    pair_init;
        logic    pair_step;
        logic    commit;
        t_status kind;
    } t_dp_cmd;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic out_free;
        logic crc_last;
        logic syn_zero;
        logic single_hit;
        logic single_last;
        logic pair_hit;
        logic pair_last;
    } t_dp_sts;

    // One byte through the CRC register, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Syndrome of a single set word bit; called with constants only.
    function automatic logic [15:0] crc_bit_syn(input int idx, input int nbytes);
        logic [WORD_W-1:0] w;
        logic [15:0]       c;
        w = WORD_W'(1) << idx;
        c = '0;
        for (int b = 0; b < nbytes; b++) begin
            c = crc_byte(c, w[b*8 +: 8]);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crc16cbc_if.sv */
// Valid/ready channel interfaces for the received and corrected callsign words.
`timescale 1ns / 1ps

interface crc16cbc_in_if;
    import crc16cbc_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] received_word;
    modport source (output valid, output received_word, input ready);
    modport sink   (input valid, input received_word, output ready);
endinterface

interface crc16cbc_out_if;
    import crc16cbc_pkg::*;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   corrected_word;
    logic [STATUS_W-1:0] status;
    modport source (output valid, output corrected_word, output status, input ready);
    modport sink   (input valid, input corrected_word, input status, output ready);
endinterface

/* hw/rtl/crc16cbc_dp.sv */
// Datapath: word and CRC registers, syndrome table, flip indices, output register.
`timescale 1ns / 1ps

module crc16cbc_dp #(
    parameter int CALLSIGN_BYTES = crc16cbc_pkg::CB_DEFAULT_BYTES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [crc16cbc_pkg::WORD_W-1:0]      i_word,
    input  crc16cbc_pkg::t_dp_cmd                i_cmd,
    output crc16cbc_pkg::t_dp_sts                o_sts,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [crc16cbc_pkg::WORD_W-1:0]      o_corrected_word,
    output logic [crc16cbc_pkg::STATUS_W-1:0]    o_status
);
    import crc16cbc_pkg::*;

    localparam int NBITS  = CALLSIGN_BYTES * 8;
    localparam int IDX_W  = $clog2(NBITS);
    localparam int BYTE_W = $clog2(CALLSIGN_BYTES);

    logic [WORD_W-1:0]   r_word;
    logic [15:0]         r_crc, n_crc;
    logic [BYTE_W-1:0]   r_byte;
    logic [IDX_W-1:0]    r_i, n_i;
    logic [IDX_W-1:0]    r_j, n_j;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_word;
    logic [STATUS_W-1:0] r_out_status;

    logic [15:0]         w_syn_tab [NBITS];
    logic [15:0]         w_syn_i, w_syn_j;
    logic [WORD_W-1:0]   w_mask_i, w_mask_j, w_fixed;
    logic                w_out_free;

    for (genvar g = 0; g < NBITS; g++) begin : g_syn
        assign w_syn_tab[g] = crc_bit_syn(g, CALLSIGN_BYTES);
    end

    assign w_syn_i    = w_syn_tab[r_i];
    assign w_syn_j    = w_syn_tab[r_j];
    assign w_mask_i   = WORD_W'(1) << r_i;
    assign w_mask_j   = WORD_W'(1) << r_j;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_crc = crc_byte(r_crc, r_word[{r_byte, 3'b000} +: 8]);
    end

    // Pair order: j runs up to the last bit, then i advances and j restarts at i+1.
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        if (i_cmd.single_init || i_cmd.pair_init) begin
            n_i = '0;
            n_j = IDX_W'(1);
        end else if (i_cmd.single_step) begin
            n_i = r_i + IDX_W'(1);
        end else if (i_cmd.pair_step) begin
            if (r_j == IDX_W'(NBITS - 1)) begin
                n_i = r_i + IDX_W'(1);
                n_j = r_i + IDX_W'(2);
            end else begin
                n_j = r_j + IDX_W'(1);
            end
        end
    end

    always_comb begin
        case (i_cmd.kind)
            ST_SINGLE: w_fixed = r_word ^ w_mask_i;
            ST_DOUBLE: w_fixed = r_word ^ w_mask_i ^ w_mask_j;
            default:   w_fixed = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_word;
            r_crc  <= '0;
            r_byte <= '0;
        end else if (i_cmd.crc_step) begin
            r_crc  <= n_crc;
            r_byte <= r_byte + BYTE_W'(1);
        end
        r_i <= n_i;
        r_j <= n_j;
        if (i_cmd.commit) begin
            r_out_word   <= w_fixed;
            r_out_status <= i_cmd.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free    = w_out_free;
    assign o_sts.crc_last    = (r_byte == BYTE_W'(CALLSIGN_BYTES - 1));
    assign o_sts.syn_zero    = (r_crc == '0);
    assign o_sts.single_hit  = (w_syn_i == r_crc);
    assign o_sts.single_last = (r_i == IDX_W'(NBITS - 1));
    assign o_sts.pair_hit    = ((w_syn_i ^ w_syn_j) == r_crc);
    assign o_sts.pair_last   = (r_i == IDX_W'(NBITS - 2)) && (r_j == IDX_W'(NBITS - 1));

    assign o_out_valid      = r_out_valid;
    assign o_corrected_word = r_out_word;
    assign o_status         = r_out_status;

`ifndef SYNTHESIS
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pair_step |-> (r_j > r_i))
        else $error("pair search left the i < j order");

    a_commit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && i_cmd.kind == ST_OK) |-> (r_crc == '0))
        else $error("clean result committed with nonzero syndrome");

    a_commit_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && i_cmd.kind == ST_DOUBLE) |-> ((w_syn_i ^ w_syn_j) == r_crc))
        else $error("double fix committed without a syndrome match");
`endif

endmodule

/* hw/rtl/crc16cbc_ctrl.sv */
// Sequencer: CRC pass, single flip search, pair search, result hand-off.
`timescale 1ns / 1ps

module crc16cbc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output crc16cbc_pkg::t_dp_cmd o_cmd,
    input  crc16cbc_pkg::t_dp_sts i_sts
);
    import crc16cbc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CRC    = 6'b000010,
        S_CHECK  = 6'b000100,
        S_SINGLE = 6'b001000,
        S_PAIR   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    t_status r_result, n_result;

    always_comb begin
        n_state  = r_state;
        n_result = r_result;
        o_cmd    = '0;
        o_cmd.kind = r_result;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CRC;
                end
            end
            S_CRC: begin
                o_cmd.crc_step = 1'b1;
                if (i_sts.crc_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.syn_zero) begin
                    n_result = ST_OK;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.single_init = 1'b1;
                    n_state           = S_SINGLE;
                end
            end
            S_SINGLE: begin
                if (i_sts.single_hit) begin
                    n_result = ST_SINGLE;
                    n_state  = S_FINISH;
                end else if (i_sts.single_last) begin
                    o_cmd.pair_init = 1'b1;
                    n_state         = S_PAIR;
                end else begin
                    o_cmd.single_step = 1'b1;
                end
            end
            S_PAIR: begin
                if (i_sts.pair_hit) begin
                    n_result = ST_DOUBLE;
                    n_state  = S_FINISH;
                end else if (i_sts.pair_last) begin
                    n_result = ST_FAIL;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.pair_step = 1'b1;
                end
            end
            S_FINISH: begin
                // hold the indices until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_result <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
        end
    end

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("result committed over an untaken result");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_CRC))
        else $error("accepted word did not start the CRC pass");
`endif

endmodule

/* hw/rtl/crc16_callsign_bit_corrector.sv */
// Top level of the CRC-16 callsign checker with single and double bit correction.
`timescale 1ns / 1ps

// Takes one received callsign word per transfer on i_in and returns one
// transfer on o_out with the corrected word and a status (0 clean, 1 single
// bit fixed, 2 double bit fixed, 3 uncorrectable, word returned unchanged).
// The CRC-16 (poly 0x1021, init 0, MSB first, no final xor) runs over the
// CALLSIGN_BYTES low bytes, CRC bytes included; bits above them are never
// flipped. One word is worked on at a time. After the input transfer the
// word is loaded, the CRC pass runs over its bytes and the syndrome is
// checked; a nonzero syndrome starts the single-bit trials (up to
// N = 8*CALLSIGN_BYTES), then the pair trials (up to N*(N-1)/2). The
// result goes into the output register once that register is free.
// The search runs through the syndrome compare, which checks one flip
// candidate per cycle against a constant table of single-bit syndromes.
// The next word is taken as soon as the result sits in the output
// register, even if it has not been taken yet.

module crc16_callsign_bit_corrector #(
    parameter int CALLSIGN_BYTES = crc16cbc_pkg::CB_DEFAULT_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    crc16cbc_in_if.sink    i_in,
    crc16cbc_out_if.source o_out
);
    import crc16cbc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // sequencer: decides which trial runs next
    crc16cbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // datapath: CRC byte step, syndrome compare, output register
    crc16cbc_dp #(
        .CALLSIGN_BYTES (CALLSIGN_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_word           (i_in.received_word),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_corrected_word (o_out.corrected_word),
        .o_status         (o_out.status)
    );

    assign i_in.ready = w_in_ready;

endmodule
